// ----- hdl/gtrp_pkg.sv -----
// shared types and constants for the pin table record parser
// used by gtrp_rec_decode and gpio_table_record_parser, no dependencies
package gtrp_pkg;

	localparam int unsigned MaxRecBytes = 5;

	// table versions
	localparam logic [7:0] VER_10 = 8'h10;
	localparam logic [7:0] VER_30 = 8'h30;
	localparam logic [7:0] VER_31 = 8'h31;
	localparam logic [7:0] VER_40 = 8'h40;
	localparam logic [7:0] VER_41 = 8'h41;

	localparam logic [5:0] OLD_TAG_UNUSED = 6'h3f;
	localparam logic [7:0] TAG_UNUSED     = 8'hff;

	typedef enum logic [2:0] {
		KIND_HDR_OK      = 3'd0,
		KIND_ENTRY       = 3'd1,
		KIND_BAD_VERSION = 3'd2,
		KIND_HDR_SHORT   = 3'd3,
		KIND_REC_SHORT   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_HEADER  = 3'b010,
		PH_RECORDS = 3'b100
	} phase_t;

	typedef logic [MaxRecBytes-1:0][7:0] rec_bytes_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  count_or_index;
		logic [5:0]  pin_line;
		logic [7:0]  function_tag;
		logic [1:0]  logic_a;
		logic [1:0]  logic_b;
		logic        param_bit;
		logic        default_level;
		logic [1:0]  special_mode;
		logic [7:0]  special_out;
		logic [4:0]  special_in;
		logic [17:0] extra_bits;
	} res_t;

	// expected header length, zero for an unknown version
	function automatic logic [7:0] want_hlen(input logic [7:0] v);
		logic [7:0] r;
		unique case (v)
			VER_10:                 r = 8'd3;
			VER_30:                 r = 8'd4;
			VER_31, VER_40, VER_41: r = 8'd6;
			default:                r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] want_rlen(input logic [7:0] v);
		logic [7:0] r;
		unique case (v)
			VER_10, VER_30, VER_31: r = 8'd2;
			VER_40:                 r = 8'd4;
			VER_41:                 r = 8'd5;
			default:                r = 8'd0;
		endcase
		return r;
	endfunction

	// header byte position on which the header result goes out
	function automatic logic [7:0] header_done_pos(input logic [7:0] v);
		logic [7:0] r;
		priority if (v == VER_10) r = 8'd2;
		else if (v == VER_30)     r = 8'd3;
		else                      r = 8'd5;
		return r;
	endfunction

endpackage

// ----- hdl/gtrp_rec_decode.sv -----
// unpacks one pin record into entry fields for the three record layouts
// depends on gtrp_pkg
module gtrp_rec_decode (
	input  logic [7:0]          version,
	input  logic [7:0]          entry_index,
	input  gtrp_pkg::rec_bytes_t rec,
	output gtrp_pkg::res_t      res
);

	logic [15:0] val;
	logic [5:0]  old_tag;

	assign val     = {rec[1], rec[0]};
	assign old_tag = val[10:5];

	always_comb begin
		res                = '0;
		res.kind           = gtrp_pkg::KIND_ENTRY;
		res.count_or_index = entry_index;
		priority if (version == gtrp_pkg::VER_40) begin
			res.pin_line      = {1'b0, rec[0][4:0]};
			res.function_tag  = rec[1];
			res.logic_a       = rec[3][4:3];
			res.logic_b       = rec[3][6:5];
			res.param_bit     = rec[3][7];
			res.default_level = rec[3][0];
			res.special_mode  = rec[3][2:1];
			res.extra_bits    = {7'd0, rec[2], rec[0][7:5]};
		end else if (version == gtrp_pkg::VER_41) begin
			res.pin_line      = rec[0][5:0];
			res.function_tag  = rec[1];
			res.logic_a       = rec[4][5:4];
			res.logic_b       = rec[4][7:6];
			res.param_bit     = rec[3][7];
			res.default_level = rec[0][7];
			res.special_out   = rec[2];
			res.special_in    = rec[3][4:0];
			res.extra_bits    = {11'd0, rec[4][3:0], rec[3][6], rec[3][5], rec[0][6]};
		end else begin
			// old two-byte layout, all-ones tag means unused
			res.pin_line     = {1'b0, val[4:0]};
			res.function_tag = (old_tag == gtrp_pkg::OLD_TAG_UNUSED) ?
				gtrp_pkg::TAG_UNUSED : {2'b00, old_tag};
			res.logic_a      = val[12:11];
			res.logic_b      = val[14:13];
			res.param_bit    = val[15];
		end
	end

endmodule

// ----- hdl/gpio_table_record_parser.sv -----
// Pin table record parser. Takes one table byte per beat; a beat with s_tuser
// set is the version byte of a new table and abandons any table in progress.
// Every byte is handled in the cycle it is accepted, so the block takes one byte
// per clock unless input is refused, and a result appears on the master side in
// the cycle after the byte that causes it, held in the output register. Input is
// refused only while that register holds a result the master side has not taken.
// Depends on gtrp_pkg and gtrp_rec_decode.
module gpio_table_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // table_start
	output logic        m_tvalid,
	input  logic        m_tready,
	// count_or_index[7:0], pin_line[13:8], function_tag[21:14], logic_a[23:22],
	// logic_b[25:24], param_bit[26], default_level[27], special_mode[29:28],
	// special_out[37:30], special_in[42:38], extra_bits[60:43], zero[63:61]
	output logic [63:0] m_tdata,
	output logic [2:0]  m_tuser    // kind
);

	gtrp_pkg::phase_t     phase_q, phase_n;
	logic [7:0]           header_pos_q, header_pos_n;
	logic [7:0]           version_q, version_n;
	logic [7:0]           header_len_q, header_len_n;
	logic [7:0]           record_len_q, record_len_n;
	logic [7:0]           entry_total_q, entry_total_n;
	logic [7:0]           entry_pos_q, entry_pos_n;
	logic [7:0]           record_pos_q, record_pos_n;
	logic [7:0]           subdir_low_q, subdir_low_n;
	gtrp_pkg::rec_bytes_t rec_q, rec_view;

	logic           accept;
	logic           emit;
	gtrp_pkg::res_t res, ent_res, out_q;
	logic           out_valid_q;

	logic [7:0] b;
	logic [7:0] p;
	logic [7:0] hlen_w, rlen_w, done_pos, check_pos;

	assign b        = s_tdata;
	assign p        = header_pos_q;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	assign hlen_w    = gtrp_pkg::want_hlen(version_q);
	assign rlen_w    = gtrp_pkg::want_rlen(version_q);
	assign done_pos  = gtrp_pkg::header_done_pos(version_q);
	assign check_pos = (version_q == gtrp_pkg::VER_10) ? 8'd2 : 8'd3;

	// the record as it stands once this beat's byte is in place
	always_comb begin
		for (int k = 0; k < gtrp_pkg::MaxRecBytes; k++) begin
			rec_view[k] = (record_pos_q == 8'(k)) ? b : rec_q[k];
		end
	end

	gtrp_rec_decode u_dec (
		.version     (version_q),
		.entry_index (entry_pos_q),
		.rec         (rec_view),
		.res         (ent_res)
	);

	always_comb begin
		phase_n       = phase_q;
		header_pos_n  = header_pos_q;
		version_n     = version_q;
		header_len_n  = header_len_q;
		record_len_n  = record_len_q;
		entry_total_n = entry_total_q;
		entry_pos_n   = entry_pos_q;
		record_pos_n  = record_pos_q;
		subdir_low_n  = subdir_low_q;
		emit          = 1'b0;
		res           = '0;

		if (s_tuser) begin
			phase_n       = gtrp_pkg::PH_HEADER;
			header_pos_n  = 8'd1;
			version_n     = b;
			header_len_n  = (b == gtrp_pkg::VER_10) ? 8'd3 : 8'd0;
			record_len_n  = 8'd0;
			entry_total_n = 8'd0;
			entry_pos_n   = 8'd0;
			record_pos_n  = 8'd0;
			subdir_low_n  = 8'd0;
			if (gtrp_pkg::want_hlen(b) == 8'd0) begin
				phase_n  = gtrp_pkg::PH_IDLE;
				emit     = 1'b1;
				res.kind = gtrp_pkg::KIND_BAD_VERSION;
			end
		end else begin
			unique case (phase_q)
				gtrp_pkg::PH_IDLE: begin
				end
				gtrp_pkg::PH_HEADER: begin
					if (header_pos_q != 8'hff) header_pos_n = header_pos_q + 8'd1;
					if (version_q == gtrp_pkg::VER_10) begin
						if (p == 8'd1) record_len_n = b;
						else if (p == 8'd2) entry_total_n = b;
					end else begin
						if (p == 8'd1) header_len_n = b;
						else if (p == 8'd2) entry_total_n = b;
						else if (p == 8'd3) record_len_n = b;
						else if (p == 8'd4) subdir_low_n = b;
					end
					priority if (p == check_pos && header_len_n < hlen_w) begin
						emit     = 1'b1;
						res.kind = gtrp_pkg::KIND_HDR_SHORT;
						phase_n  = gtrp_pkg::PH_IDLE;
					end else if (p == check_pos && record_len_n < rlen_w) begin
						emit     = 1'b1;
						res.kind = gtrp_pkg::KIND_REC_SHORT;
						phase_n  = gtrp_pkg::PH_IDLE;
					end else begin
						if (p == done_pos) begin
							emit               = 1'b1;
							res.kind           = gtrp_pkg::KIND_HDR_OK;
							res.count_or_index = entry_total_n;
							if (done_pos == 8'd5) res.extra_bits[15:0] = {b, subdir_low_q};
							res.extra_bits[16] = header_len_n > hlen_w;
							res.extra_bits[17] = record_len_n > rlen_w;
						end
						// header bytes past the expected length are skipped
						if (p >= done_pos && header_pos_n >= header_len_n) begin
							entry_pos_n  = 8'd0;
							record_pos_n = 8'd0;
							phase_n      = (entry_total_n != 8'd0) ?
								gtrp_pkg::PH_RECORDS : gtrp_pkg::PH_IDLE;
						end
					end
				end
				gtrp_pkg::PH_RECORDS: begin
					record_pos_n = record_pos_q + 8'd1;
					if (record_pos_q == rlen_w - 8'd1) begin
						emit = 1'b1;
						res  = ent_res;
					end
					if (record_pos_n >= record_len_q) begin
						record_pos_n = 8'd0;
						entry_pos_n  = entry_pos_q + 8'd1;
						if (entry_pos_n >= entry_total_q) phase_n = gtrp_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_n = gtrp_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= gtrp_pkg::PH_IDLE;
			header_pos_q  <= 8'd0;
			version_q     <= 8'd0;
			header_len_q  <= 8'd0;
			record_len_q  <= 8'd0;
			entry_total_q <= 8'd0;
			entry_pos_q   <= 8'd0;
			record_pos_q  <= 8'd0;
			subdir_low_q  <= 8'd0;
		end else if (accept) begin
			phase_q       <= phase_n;
			header_pos_q  <= header_pos_n;
			version_q     <= version_n;
			header_len_q  <= header_len_n;
			record_len_q  <= record_len_n;
			entry_total_q <= entry_total_n;
			entry_pos_q   <= entry_pos_n;
			record_pos_q  <= record_pos_n;
			subdir_low_q  <= subdir_low_n;
		end
	end

	// record byte store, no reset
	always_ff @(posedge clk) begin
		for (int k = 0; k < gtrp_pkg::MaxRecBytes; k++) begin
			if (accept && !s_tuser && phase_q == gtrp_pkg::PH_RECORDS &&
			    record_pos_q == 8'(k)) begin
				rec_q[k] <= b;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {3'b000, out_q.extra_bits, out_q.special_in, out_q.special_out,
		out_q.special_mode, out_q.default_level, out_q.param_bit, out_q.logic_b,
		out_q.logic_a, out_q.function_tag, out_q.pin_line, out_q.count_or_index};

endmodule
